FILE: rtl/gmi_pkg.sv
// Package: shared types and constants for the genetic map interpolator.
package gmi_pkg;

  localparam int MaxEntries = 4096;
  localparam int AddrW = $clog2(MaxEntries);
  localparam int CountW = AddrW + 1;

  localparam int PosW = 31;
  localparam int ValW = 32;
  localparam int RateW = 24;
  localparam int ResW = 33;

  // rate times distance, its rounded value and the interpolated sum
  localparam int ProdW = RateW + PosW;
  localparam int RndW = ProdW - 15;
  localparam int SumW = RndW + 1;

  localparam int InUserW = 2;     // operation
  localparam int InDataW = 120;   // 31+31+32+24 padded
  localparam int OutDataW = 40;   // 33+2 padded

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_SPAN  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_CSTART = 2'd0,
    REG_CEND   = 2'd1,
    REG_CVALUE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [ValW-1:0]  val;
    logic [RateW-1:0] rate;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_COMPARE,
    S_ENTRY,
    S_MUL,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

FILE: rtl/genetic_map_interpolator_unit.sv
// Top level: sorted map table with binary-search lookup and linear interpolation.
//
// Input stream s_axis: one transaction per item; tuser carries the operation
// (load entry, point query, interval query), tdata the positions, value and rate.
// Output stream m_axis: exactly one result per input item, in order.
// The block works on one item at a time and raises s_axis_tready only when idle.
// A load, an unused code, an empty table or a query that needs no search passes
// from acceptance through the decide and done states only. A search pass runs the
// binary-search steps, each a table read from the registered read port and then a
// compare, then a read of the chosen entry, a multiply and the interpolation. A point
// query runs at most one search pass, an interval query with both ends interpolated
// runs two. The block returns to idle before it takes the next item.
// Configuration: cfg_we writes centromere_start, centromere_end or
// centromere_value by cfg_index; the user must write only while no item is in flight,
// as the block does not enforce it. Reset clears the entry count, the registers and
// the handshake state; table contents stay, since only entries below the count are
// read. When the receiver stalls, a result waits in the output register; the next
// item is still taken, and its finished result holds the block until the register frees.
module genetic_map_interpolator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // position[30:0], position_end[61:31], entry_genetic[93:62], entry_rate[117:94],
  // zero fill [119:118]
  input  logic [gmi_pkg::InDataW-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [gmi_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // genetic_result[32:0] signed, status[34:33], zero fill [39:35]
  output logic [gmi_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import gmi_pkg::*;

  // table memory
  entry_t           mem_entry [MaxEntries];
  entry_t           rd_entry;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;

  // item registers
  op_t              op;
  logic [PosW-1:0]  pos, pend;
  logic [ValW-1:0]  gen;
  logic [RateW-1:0] rate_in;

  logic [PosW-1:0]  cstart, cend;
  logic [ValW-1:0]  cvalue;

  logic [CountW-1:0] count;
  logic [PosW-1:0]   first_pos, last_pos;
  logic [ValW-1:0]   last_val;
  state_t            state, state_next;

  logic [AddrW-1:0] lo, hi, mid, last_idx;
  logic [AddrW:0]   span_sum;
  logic [PosW-1:0]  key;
  logic             pass_end;     // current pass interpolates the interval end
  logic             end_pending;  // an end pass follows the start pass
  logic [ValW-1:0]  sv, ev;       // start and end values
  logic [PosW-1:0]  delta;
  logic [RateW-1:0] erate;
  logic [ValW-1:0]  evalue;
  logic [ProdW-1:0] prod;
  logic [ProdW:0]   prod_round;
  logic [RndW-1:0]  dround;
  logic [SumW-1:0]  fwd;
  logic [ValW-1:0]  fwd_sat, bwd;
  logic [ResW-1:0]  result;
  status_t          status;

  logic accept, out_free;
  logic empty, table_full, order_bad, gap_s, gap_e;
  logic point_live, span_live, start_fixed, end_fixed, need_fwd, need_bwd;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  function automatic logic in_gap(input logic [PosW-1:0] p, input logic [PosW-1:0] a,
                                  input logic [PosW-1:0] b);
    in_gap = (p >= a) && (p <= b);
  endfunction

  // classify the held item
  assign empty = (count == '0);
  assign table_full = (count == CountW'(MaxEntries));
  assign order_bad = !empty && (pos <= last_pos);
  assign gap_s = in_gap(pos, cstart, cend);
  assign gap_e = in_gap(pend, cstart, cend);
  assign point_live = (op == OP_POINT) && !empty && (pos > first_pos);
  assign span_live = (op == OP_SPAN) && !empty && !(gap_s && gap_e) &&
                     (pend > first_pos) && (pos < last_pos);
  assign start_fixed = (pos <= first_pos) || gap_s;
  assign end_fixed = (pend >= last_pos) || gap_e;
  assign need_fwd = (point_live && (pos < last_pos) && !gap_s) ||
                    (span_live && !start_fixed);
  assign need_bwd = span_live && !end_fixed;
  assign wr_en = (state == S_DECIDE) && (op == OP_LOAD) && !table_full && !order_bad;

  // search midpoint: upper for forward search, lower for backward
  assign span_sum = {1'b0, lo} + {1'b0, hi} + {{AddrW{1'b0}}, !pass_end};
  assign mid = span_sum[AddrW:1];
  assign key = pass_end ? pend : pos;
  assign last_idx = AddrW'(count - CountW'(1));

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem_entry[count[AddrW-1:0]] <= {pos, gen, rate_in};
    rd_entry <= mem_entry[rd_addr];
  end

  // next state and read address
  always_comb begin
    state_next = state;
    rd_addr = mid;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECIDE;
      end
      S_DECIDE: state_next = (need_fwd || need_bwd) ? S_SEARCH : S_DONE;
      S_SEARCH: begin
        if (lo == hi) begin
          rd_addr = lo;
          state_next = S_ENTRY;
        end else begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: state_next = S_SEARCH;
      S_ENTRY: state_next = S_MUL;
      S_MUL: state_next = S_EVAL;
      S_EVAL: state_next = (!pass_end && end_pending) ? S_SEARCH : S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // count, configuration and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cstart <= '0;
      cend <= '0;
      cvalue <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_CSTART: cstart <= cfg_data[PosW-1:0];
          REG_CEND:   cend <= cfg_data[PosW-1:0];
          REG_CVALUE: cvalue <= cfg_data;
          default: ;
        endcase
      end
      if (wr_en) count <= count + CountW'(1);
      if (state == S_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // rounded rate times distance, then forward (saturating) or backward (floored) value
  assign prod_round = {1'b0, prod} + (ProdW+1)'(32768);
  assign dround = prod_round[ProdW:16];
  assign fwd = SumW'(evalue) + SumW'(dround);
  assign fwd_sat = (fwd[SumW-1:ValW] != '0) ? '1 : fwd[ValW-1:0];
  assign bwd = (dround > RndW'(evalue)) ? '0 : (evalue - dround[ValW-1:0]);
  assign result = {1'b0, ev} - {1'b0, sv};

  // datapath
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_pos <= pos;
      last_val <= gen;
      if (empty) first_pos <= pos;
    end
    if (state == S_DONE && out_free) m_axis_tdata <= {5'b0, status, result};
    case (state)
      S_IDLE: begin
        if (accept) begin
          op      <= op_t'(s_axis_tuser);
          pos     <= s_axis_tdata[30:0];
          pend    <= s_axis_tdata[61:31];
          gen     <= s_axis_tdata[93:62];
          rate_in <= s_axis_tdata[117:94];
        end
      end
      S_DECIDE: begin
        if (op == OP_LOAD && table_full) status <= ST_FULL;
        else if (op == OP_LOAD && order_bad) status <= ST_ORDER;
        else status <= ST_OK;
        // fix the values that need no search
        sv <= (span_live && gap_s) ? cvalue : '0;
        if (span_live) ev <= gap_e ? cvalue : ((pend >= last_pos) ? last_val : '0);
        else if (point_live && pos >= last_pos) ev <= last_val;
        else if (point_live && gap_s) ev <= cvalue;
        else ev <= '0;
        pass_end <= !need_fwd;
        end_pending <= need_bwd;
        lo <= '0;
        hi <= last_idx;
      end
      S_COMPARE: begin
        if (!pass_end) begin
          if (rd_entry.pos <= key) lo <= mid; else hi <= mid - AddrW'(1);
        end else begin
          if (rd_entry.pos >= key) hi <= mid; else lo <= mid + AddrW'(1);
        end
      end
      S_ENTRY: begin
        delta  <= pass_end ? (rd_entry.pos - pend) : (pos - rd_entry.pos);
        erate  <= rd_entry.rate;
        evalue <= rd_entry.val;
      end
      S_MUL: begin
        prod <= {{PosW{1'b0}}, erate} * {{RateW{1'b0}}, delta};
      end
      S_EVAL: begin
        if (!pass_end) begin
          if (op == OP_POINT) ev <= fwd_sat; else sv <= fwd_sat;
        end else begin
          ev <= bwd;
        end
        // start the end pass after the start pass
        if (!pass_end && end_pending) begin
          pass_end <= 1'b1;
          lo <= '0;
          hi <= last_idx;
        end
      end
      default: ;
    endcase
  end

  // hold the result while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  // never count past the table depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxEntries));
  // never write into a full table
  a_write: assert property (@(posedge clk) disable iff (rst) wr_en |-> !table_full);
  // take input only when idle
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE);
  // report only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[ResW+1:ResW] <= 2'(ST_ORDER));

endmodule
